[rtl/core/tssf_pkg.sv]
// ----------------------------------------------------------------------------
// tssf_pkg
// types and codes shared by the server segment connection block
// ----------------------------------------------------------------------------
package tssf_pkg;

   // configuration port
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int NUM_PORT_REGS = 4;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_CONN_PORT_0     = 3'd0;
   localparam logic [2:0] REG_CONN_PORT_1     = 3'd1;
   localparam logic [2:0] REG_CONN_PORT_2     = 3'd2;
   localparam logic [2:0] REG_CONN_PORT_3     = 3'd3;
   localparam logic [2:0] REG_CLOSE_TIMEOUT   = 3'd4;

   localparam logic [15:0] CLOSE_TIMEOUT_RESET = 16'd1000;

   // request opcodes
   localparam logic [2:0] OP_SYN     = 3'd0;
   localparam logic [2:0] OP_FIN     = 3'd1;
   localparam logic [2:0] OP_DATA    = 3'd2;
   localparam logic [2:0] OP_DATAACK = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;
   localparam logic [2:0] OP_LISTEN  = 3'd5;

   // reply kinds
   localparam logic [1:0] RT_SYNACK  = 2'd0;
   localparam logic [1:0] RT_FINACK  = 2'd1;
   localparam logic [1:0] RT_DATAACK = 2'd2;

   // per-entry connection state
   typedef enum logic [3:0] {
      ST_CLOSED    = 4'b0001,
      ST_LISTENING = 4'b0010,
      ST_CONNECTED = 4'b0100,
      ST_CLOSEWAIT = 4'b1000
   } conn_state_type;

   // request tdata, lowest field in the lowest bits
   typedef struct packed {
      logic [4:0]  pad;
      logic [10:0] data_len;
      logic [31:0] ack_num;
      logic [31:0] seq_num;
      logic [7:0]  src_node;
      logic [15:0] seg_sport;
      logic [15:0] seg_dport;
   } req_data_type;

   // response tdata, lowest field in the lowest bits
   typedef struct packed {
      logic        status;
      logic [1:0]  conn_index;
      logic [10:0] accept_len;
      logic        accept_valid;
      logic [31:0] reply_ack_num;
      logic [31:0] reply_seq_num;
      logic [7:0]  reply_node;
      logic [15:0] reply_dest_port;
      logic [15:0] reply_src_port;
      logic        reply_valid;
   } rsp_data_type;

endpackage

[rtl/core/transport_server_segment_fsm_unit.sv]
// ----------------------------------------------------------------------------
// transport_server_segment_fsm_unit
// server side connection state machine: port match, listen/syn/fin/data handling,
// acknowledgement generation and close-wait timeout on tick requests
// ----------------------------------------------------------------------------
// path: an accepted request is held in the input register, then its response
//   is held in the response register until rsp_tready takes it
// throughput: one request per cycle unless the response output stalls; the per-entry state
//   read, update and write back happen combinationally between the two registers
// reset: synchronous, active high; all entries return to closed with zeroed
//   state, port registers clear, close timeout returns to 1000, no sweep
module transport_server_segment_fsm_unit #(
   parameter int NUM_CONNS   = 4,
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // seg_dport[15:0], seg_sport[31:16], src_node[39:32], seq_num[71:40],
   // ack_num[103:72], data_len[114:104], zero pad[119:115]
   input  logic [119:0]                        req_tdata,
   // opcode[2:0], zero pad[7:3]
   input  logic [7:0]                          req_tuser,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // reply_valid[0], reply_src_port[16:1], reply_dest_port[32:17],
   // reply_node[40:33], reply_seq_num[72:41], reply_ack_num[104:73],
   // accept_valid[105], accept_len[116:106], conn_index[118:117], status[119]
   output logic [119:0]                        rsp_tdata,
   // reply_type[1:0], zero pad[7:2]
   output logic [7:0]                          rsp_tuser,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tssf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tssf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tssf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;
   localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

   // configuration registers
   logic [15:0] port_ff [tssf_pkg::NUM_PORT_REGS];
   logic [15:0] timeout_ff;

   // input register
   logic                   item_valid_ff, item_valid_in;
   tssf_pkg::req_data_type item_ff;
   logic [2:0]             item_op_ff;

   // per-entry state
   tssf_pkg::conn_state_type state_ff [NUM_CONNS];
   tssf_pkg::conn_state_type state_in [NUM_CONNS];
   logic [31:0] exp_seq_ff [NUM_CONNS];
   logic [31:0] exp_seq_in [NUM_CONNS];
   logic [15:0] cli_port_ff [NUM_CONNS];
   logic [15:0] cli_port_in [NUM_CONNS];
   logic [7:0]  cli_node_ff [NUM_CONNS];
   logic [7:0]  cli_node_in [NUM_CONNS];
   logic [15:0] countdown_ff [NUM_CONNS];
   logic [15:0] countdown_in [NUM_CONNS];

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   tssf_pkg::rsp_data_type rsp_ff, rsp_in;
   logic [1:0]             rsp_type_ff, rsp_type_in;

   logic       advance;
   logic       csr_write;
   logic [2:0] csr_idx;
   logic [15:0] port_tab [NUM_CONNS];

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tssf_pkg::NUM_PORT_REGS; i++) begin
            port_ff[i] <= '0;
         end
         timeout_ff <= tssf_pkg::CLOSE_TIMEOUT_RESET;
      end else if (csr_write) begin
         if (csr_idx == tssf_pkg::REG_CLOSE_TIMEOUT) begin
            timeout_ff <= csr_pwdata[15:0];
         end else if ((csr_idx < 3'(tssf_pkg::NUM_PORT_REGS)) &&
                      (32'(csr_idx) < 32'(NUM_CONNS))) begin
            port_ff[csr_idx[1:0]] <= csr_pwdata[15:0];
         end
      end
   end

   // configuration read
   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         tssf_pkg::REG_CLOSE_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
         tssf_pkg::REG_CONN_PORT_0,
         tssf_pkg::REG_CONN_PORT_1,
         tssf_pkg::REG_CONN_PORT_2,
         tssf_pkg::REG_CONN_PORT_3: begin
            if (32'(csr_idx) < 32'(NUM_CONNS)) begin
               csr_prdata = {16'd0, port_ff[csr_idx[1:0]]};
            end
         end
         default: csr_prdata = '0;
      endcase
   end

   // server port of each entry; entries past the port registers stay unused
   always_comb begin
      for (int k = 0; k < NUM_CONNS; k++) begin
         if (k < tssf_pkg::NUM_PORT_REGS) begin
            port_tab[k] = port_ff[2'(k)];
         end else begin
            port_tab[k] = '0;
         end
      end
   end

   // stage handshake
   assign advance    = item_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~item_valid_ff | advance;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_tvalid && req_tready) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff    <= req_tdata;
         item_op_ff <= req_tuser[2:0];
      end
   end

   // request processing: port match, entry update and response build
   always_comb begin
      logic             hit;
      logic [IDX_W-1:0] idx;
      logic [1:0]       idx_out;
      logic [16:0]      len_sat;
      logic [15:0]      cnt_dec;

      hit     = 1'b0;
      idx     = '0;
      idx_out = '0;
      len_sat = {6'd0, item_ff.data_len};
      if (len_sat > MAX_LEN) begin
         len_sat = MAX_LEN;
      end
      cnt_dec = '0;

      for (int k = 0; k < NUM_CONNS; k++) begin
         state_in[k]     = state_ff[k];
         exp_seq_in[k]   = exp_seq_ff[k];
         cli_port_in[k]  = cli_port_ff[k];
         cli_node_in[k]  = cli_node_ff[k];
         countdown_in[k] = countdown_ff[k];
      end

      // lowest matching entry wins; port zero never matches
      for (int k = NUM_CONNS - 1; k >= 0; k--) begin
         if ((port_tab[k] != 16'd0) && (port_tab[k] == item_ff.seg_dport)) begin
            hit     = 1'b1;
            idx     = IDX_W'(k);
            idx_out = 2'(k);
         end
      end

      rsp_in      = '0;
      rsp_type_in = '0;

      if (item_op_ff == tssf_pkg::OP_TICK) begin
         // close-wait entries count down, closing at zero
         for (int k = 0; k < NUM_CONNS; k++) begin
            if (state_ff[k] == tssf_pkg::ST_CLOSEWAIT) begin
               cnt_dec = countdown_ff[k];
               if (cnt_dec != 16'd0) begin
                  cnt_dec = cnt_dec - 16'd1;
               end
               countdown_in[k] = cnt_dec;
               if (cnt_dec == 16'd0) begin
                  state_in[k] = tssf_pkg::ST_CLOSED;
               end
            end
         end
      end else if (item_op_ff <= tssf_pkg::OP_LISTEN) begin
         if (!hit) begin
            rsp_in.status = 1'b1;
         end else begin
            rsp_in.conn_index = idx_out;
            case (item_op_ff)
               tssf_pkg::OP_SYN: begin
                  if (state_ff[idx] == tssf_pkg::ST_LISTENING) begin
                     cli_port_in[idx] = item_ff.seg_sport;
                     cli_node_in[idx] = item_ff.src_node;
                     exp_seq_in[idx]  = item_ff.seq_num;
                     state_in[idx]    = tssf_pkg::ST_CONNECTED;
                  end
                  rsp_in.reply_valid     = 1'b1;
                  rsp_type_in            = tssf_pkg::RT_SYNACK;
                  rsp_in.reply_src_port  = item_ff.seg_dport;
                  rsp_in.reply_dest_port = item_ff.seg_sport;
                  rsp_in.reply_node      = cli_node_in[idx];
                  rsp_in.reply_seq_num   = item_ff.seq_num;
                  rsp_in.reply_ack_num   = item_ff.ack_num;
               end
               tssf_pkg::OP_FIN: begin
                  if (state_ff[idx] == tssf_pkg::ST_CONNECTED) begin
                     state_in[idx]     = tssf_pkg::ST_CLOSEWAIT;
                     countdown_in[idx] = timeout_ff;
                  end
                  rsp_in.reply_valid     = 1'b1;
                  rsp_type_in            = tssf_pkg::RT_FINACK;
                  rsp_in.reply_src_port  = item_ff.seg_dport;
                  rsp_in.reply_dest_port = item_ff.seg_sport;
                  rsp_in.reply_node      = cli_node_ff[idx];
                  rsp_in.reply_seq_num   = item_ff.seq_num;
                  rsp_in.reply_ack_num   = item_ff.ack_num;
               end
               tssf_pkg::OP_DATA: begin
                  if (state_ff[idx] == tssf_pkg::ST_CONNECTED) begin
                     // in-order data moves the expected sequence on
                     if (item_ff.seq_num == exp_seq_ff[idx]) begin
                        exp_seq_in[idx]     = exp_seq_ff[idx] + {15'd0, len_sat};
                        rsp_in.accept_valid = 1'b1;
                        rsp_in.accept_len   = len_sat[10:0];
                     end
                     rsp_in.reply_valid     = 1'b1;
                     rsp_type_in            = tssf_pkg::RT_DATAACK;
                     rsp_in.reply_src_port  = item_ff.seg_dport;
                     rsp_in.reply_dest_port = item_ff.seg_sport;
                     rsp_in.reply_node      = cli_node_ff[idx];
                     rsp_in.reply_seq_num   = item_ff.seq_num;
                     rsp_in.reply_ack_num   = exp_seq_in[idx];
                  end
               end
               tssf_pkg::OP_LISTEN: begin
                  if (state_ff[idx] == tssf_pkg::ST_CLOSED) begin
                     state_in[idx] = tssf_pkg::ST_LISTENING;
                  end
               end
               default: begin
                  // dataack: matched, no effect
               end
            endcase
         end
      end
   end

   // entry state, updated as each request leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CONNS; k++) begin
            state_ff[k]     <= tssf_pkg::ST_CLOSED;
            exp_seq_ff[k]   <= '0;
            cli_port_ff[k]  <= '0;
            cli_node_ff[k]  <= '0;
            countdown_ff[k] <= '0;
         end
      end else if (advance) begin
         for (int k = 0; k < NUM_CONNS; k++) begin
            state_ff[k]     <= state_in[k];
            exp_seq_ff[k]   <= exp_seq_in[k];
            cli_port_ff[k]  <= cli_port_in[k];
            cli_node_ff[k]  <= cli_node_in[k];
            countdown_ff[k] <= countdown_in[k];
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff      <= rsp_in;
         rsp_type_ff <= rsp_type_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tuser  = {6'd0, rsp_type_ff};

   // checks
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> item_valid_ff)
      else $error("accepted request not held in input register");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed request produced no response");

   a_accept_is_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.accept_valid) |->
         (rsp_ff.reply_valid && (rsp_tuser[1:0] == tssf_pkg::RT_DATAACK)))
      else $error("accepted data without a data acknowledgement");

   a_unmatched_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.status) |->
         (!rsp_ff.reply_valid && !rsp_ff.accept_valid && (rsp_tuser[1:0] == 2'd0)))
      else $error("unmatched port produced a reply");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.accept_valid) |-> ({6'd0, rsp_ff.accept_len} <= MAX_LEN))
      else $error("accepted length above payload limit");

endmodule
